// ===== rtl/rail_fence_cipher_top_defines.svh =====
// Assertion macros shared by the rail fence cipher RTL.
`ifndef RAIL_FENCE_CIPHER_TOP_DEFINES_SVH
`define RAIL_FENCE_CIPHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfc_pkg.sv =====
// Shared types and constants of the rail fence cipher block.
package rfc_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RAIL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic idle;          // input channel open
    logic scan_init;     // start the rail-order scan
    logic pos_step;      // advance scan position along the current rail
    logic cnt_inc;       // advance the item counter
    logic next_rail;     // move the scan to the next rail
    logic scan_mark;     // record rail start offsets during the scan
    logic walk_init;     // start the zigzag walk
    logic walk_step;     // advance the zigzag walk
    logic store_rd_pos;  // read the message store at the scan position
    logic store_rd_ptr;  // read the message store at the rail pointer
    logic out_load;      // load the output register
    logic clear;         // message done, empty the buffer
  } cmd_t;

  typedef struct packed {
    logic last_accept;   // an item marked last is accepted this cycle
    logic pos_in_msg;    // scan position lies inside the message
    logic rail_last;     // scan is on the final rail
    logic decode;        // decode mode selected
    logic out_free;      // output register can take an item
    logic emit_last;     // the item being emitted ends the run
  } status_t;

endpackage

// ===== rtl/rfc_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rfc_ctrl.sv =====
// Sequencing state machine of the rail fence cipher block.
module rfc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  rfc_pkg::status_t status_i,
  output rfc_pkg::cmd_t    cmd_o
);
  import rfc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_SCAN_OUT = 6'b000100,
    ST_WALK_PTR = 6'b001000,
    ST_WALK_RD  = 6'b010000,
    ST_WALK_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (status_i.last_accept) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_mark = status_i.decode;
        if (status_i.pos_in_msg) begin
          if (status_i.decode) begin
            // Decode only counts rail lengths here.
            cmd.pos_step = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end else begin
            cmd.store_rd_pos = 1'b1;
            state_nxt        = ST_SCAN_OUT;
          end
        end else if (status_i.rail_last) begin
          if (status_i.decode) begin
            cmd.walk_init = 1'b1;
            state_nxt     = ST_WALK_PTR;
          end else begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.next_rail = 1'b1;
        end
      end
      ST_SCAN_OUT: begin
        if (status_i.out_free) begin
          cmd.out_load = 1'b1;
          cmd.pos_step = 1'b1;
          cmd.cnt_inc  = 1'b1;
          if (status_i.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WALK_PTR: begin
        state_nxt = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd.store_rd_ptr = 1'b1;
        state_nxt        = ST_WALK_OUT;
      end
      ST_WALK_OUT: begin
        if (status_i.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.walk_step = 1'b1;
          cmd.cnt_inc   = 1'b1;
          if (status_i.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WALK_PTR;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd_o = cmd;

`include "rail_fence_cipher_top_defines.svh"

  `RFC_ASSERT_NEXT(a_last_starts_scan, status_i.last_accept, state_r == ST_SCAN, "last item did not start the scan")
  `RFC_ASSERT_NEXT(a_ptr_then_read, state_r == ST_WALK_PTR, state_r == ST_WALK_RD, "walk skipped the pointer read")
  `RFC_ASSERT_NOW(a_emit_only_free, cmd.out_load, status_i.out_free, "item emitted into a busy output register")

endmodule

// ===== rtl/rfc_datapath.sv =====
// Message store, rail pointers, scan and walk counters and output register.
module rfc_datapath #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_RAILS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rfc_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfc_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last,
  output logic                               out_truncated,
  input  rfc_pkg::cmd_t                      cmd_i,
  output rfc_pkg::status_t                   status_o
);
  import rfc_pkg::*;

  localparam int AW  = $clog2(MAX_LEN);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int RIW = $clog2(MAX_RAILS);
  localparam int PW  = $clog2(MAX_LEN + 2 * MAX_RAILS);

  logic [CFG_DATA_W-1:0] cfg_rails_r;
  logic                  cfg_mode_r;

  logic [CW-1:0]  msg_len_r, msg_len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           phase_r, phase_nxt;
  logic [RIW-1:0] rail_r, rail_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [RIW-1:0] cr_r, cr_nxt;
  logic           down_r, down_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic           out_last_r, out_trunc_r;

  logic           accept;
  logic           has_room;
  logic           out_free;
  logic           emit_last;
  logic [PW-1:0]  rails_p, period, rail_p, step;
  logic [PW-1:0]  cr_p;

  logic              store_we, store_re;
  logic [AW-1:0]     store_raddr;
  logic [BYTE_W-1:0] store_rdata;
  logic              ptr_we;
  logic [RIW-1:0]    ptr_waddr;
  logic [CW-1:0]     ptr_wdata, ptr_rdata;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rails_r <= CFG_DATA_W'(2);
      cfg_mode_r  <= MODE_ENCODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RAIL_COUNT: cfg_rails_r <= cfg_wdata;
        CFG_MODE:       cfg_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective rail count: zero means one rail, large values saturate.
  always_comb begin
    if (cfg_rails_r == '0) begin
      rails_p = PW'(1);
    end else if (int'(cfg_rails_r) > MAX_RAILS) begin
      rails_p = PW'(MAX_RAILS);
    end else begin
      rails_p = PW'(cfg_rails_r);
    end
  end

  assign period = (rails_p - PW'(1)) << 1;
  assign rail_p = PW'(rail_r);
  assign cr_p   = PW'(cr_r);

  // Inner-rail positions advance by alternating gaps that add up to one period.
  always_comb begin
    if (rails_p == PW'(1)) begin
      step = PW'(1);
    end else if (rail_r == '0 || rail_p + PW'(1) == rails_p) begin
      step = period;
    end else if (phase_r) begin
      step = rail_p << 1;
    end else begin
      step = period - (rail_p << 1);
    end
  end

  assign in_stall  = !cmd_i.idle;
  assign accept    = in_valid && cmd_i.idle;
  assign has_room  = msg_len_r < CW'(MAX_LEN);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (cnt_r + CW'(1)) == msg_len_r;

  always_comb begin
    msg_len_nxt = msg_len_r;
    ovf_nxt     = ovf_r;
    if (accept) begin
      if (has_room) begin
        msg_len_nxt = msg_len_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd_i.clear) begin
      msg_len_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    rail_nxt  = rail_r;
    cnt_nxt   = cnt_r;
    cr_nxt    = cr_r;
    down_nxt  = down_r;
    if (cmd_i.scan_init) begin
      pos_nxt   = '0;
      phase_nxt = 1'b0;
      rail_nxt  = '0;
    end
    if (cmd_i.pos_step) begin
      pos_nxt   = pos_r + step;
      phase_nxt = !phase_r;
    end
    if (cmd_i.next_rail) begin
      rail_nxt  = rail_r + RIW'(1);
      pos_nxt   = rail_p + PW'(1);
      phase_nxt = 1'b0;
    end
    if (cmd_i.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd_i.scan_init || cmd_i.walk_init) begin
      cnt_nxt = '0;
    end
    if (cmd_i.walk_init) begin
      cr_nxt   = '0;
      down_nxt = 1'b1;
    end
    if (cmd_i.walk_step && rails_p > PW'(1)) begin
      if (down_r) begin
        cr_nxt = cr_r + RIW'(1);
        if (cr_p + PW'(2) >= rails_p) begin
          down_nxt = 1'b0;
        end
      end else begin
        if (cr_r != '0) begin
          cr_nxt = cr_r - RIW'(1);
        end
        if (cr_r <= RIW'(1)) begin
          down_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r   <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      phase_r     <= 1'b0;
      rail_r      <= '0;
      cnt_r       <= '0;
      cr_r        <= '0;
      down_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      msg_len_r   <= msg_len_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      rail_r      <= rail_nxt;
      cnt_r       <= cnt_nxt;
      cr_r        <= cr_nxt;
      down_r      <= down_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_byte_r  <= store_rdata;
      out_last_r  <= emit_last;
      out_trunc_r <= ovf_r;
    end
  end

  // Message store: written in arrival order, read in scan or walk order.
  assign store_we    = accept && has_room;
  assign store_re    = cmd_i.store_rd_pos || cmd_i.store_rd_ptr;
  assign store_raddr = cmd_i.store_rd_ptr ? ptr_rdata[AW-1:0] : pos_r[AW-1:0];

  rfc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (msg_len_r[AW-1:0]),
    .wdata (in_byte),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Rail pointers: start offsets from the scan, then bumped per walk step.
  assign ptr_we    = cmd_i.store_rd_ptr || (cmd_i.scan_mark && pos_r == rail_p);
  assign ptr_waddr = cmd_i.store_rd_ptr ? cr_r : rail_r;
  assign ptr_wdata = cmd_i.store_rd_ptr ? ptr_rdata + CW'(1) : cnt_r;

  rfc_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_RAILS)
  ) u_rail_ptr (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (1'b1),
    .raddr (cr_r),
    .rdata (ptr_rdata)
  );

  always_comb begin
    status_o             = '0;
    status_o.last_accept = accept && in_last;
    status_o.pos_in_msg  = pos_r < PW'(msg_len_r);
    status_o.rail_last   = rail_p + PW'(1) == rails_p;
    status_o.decode      = cfg_mode_r == MODE_DECODE;
    status_o.out_free    = out_free;
    status_o.emit_last   = emit_last;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

`include "rail_fence_cipher_top_defines.svh"

  `RFC_ASSERT_NOW(a_len_bound, 1'b1, msg_len_r <= CW'(MAX_LEN), "message length beyond the store")
  `RFC_ASSERT_NOW(a_emit_in_msg, cmd_i.out_load, cnt_r < msg_len_r, "item emitted past the message end")
  `RFC_ASSERT_NEXT(a_clear_empties, cmd_i.clear, msg_len_r == '0 && !ovf_r, "buffer not emptied after a run")

endmodule

// ===== rtl/rail_fence_cipher_top.sv =====
// Top level of the rail fence cipher block.
//
// Input channel (in_valid, in_stall, in_byte, in_last): one message byte per
// item, taken one per cycle while the block is collecting. The item with
// in_last high ends the message; up to MAX_LEN bytes are kept and later ones
// are dropped, which sets out_truncated on every result of that message.
// After the last item in_stall stays high until the final result of the run
// has been loaded into the output stage.
// Result channel (out_valid, out_stall, out_byte, out_last, out_truncated):
// one item per stored byte, out_last on the final one. A registered output
// stage holds an item while out_stall is high; the sequencer waits on it.
// Encode: after the last item is taken the block scans the store rail by rail,
// and each result takes a message store read, then an output load, with an
// extra step at each change of rail. Decode: a counting scan over the message
// and rails first, then each result takes a rail pointer read, a store read
// and an output load.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_wdata): index 0 is the
// rail count, index 1 the mode; write only while no message is in flight.
// Reset (rst_n low, synchronous) empties the buffer, sets 2 rails and encode.
module rail_fence_cipher_top #(
  parameter int MAX_LEN   = 64,
  parameter int MAX_RAILS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rfc_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rfc_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last,
  output logic                           out_truncated
);
  import rfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rfc_datapath #(
    .MAX_LEN   (MAX_LEN),
    .MAX_RAILS (MAX_RAILS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_truncated (out_truncated),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
